// File: rtl/u16u8_pkg.sv
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the command type passed from front to back and the UTF-8 byte helpers.
// No dependencies.
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [5:0] HI_TAG = 6'b110110;
    localparam logic [5:0] LO_TAG = 6'b110111;

    typedef struct packed {
        logic        flush;
        logic [9:0]  flush_bits;
        logic        main;
        logic [20:0] cp;
        logic        last;
    } cmd_t;

    // byte count minus one for a code point
    function automatic logic [1:0] utf8_nbytes_m1(input logic [20:0] cp);
        logic [1:0] nb;
        if (cp < 21'h80) begin
            nb = 2'd0;
        end else if (cp < 21'h800) begin
            nb = 2'd1;
        end else if (cp < 21'h10000) begin
            nb = 2'd2;
        end else begin
            nb = 2'd3;
        end
        return nb;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] nb,
                                             input logic [1:0] idx);
        logic [1:0] sel;
        logic [7:0] b;
        sel = nb - idx;
        if (idx == 2'd0) begin
            case (nb)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {3'b110, cp[10:6]};
                2'd2:    b = {4'b1110, cp[15:12]};
                default: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            case (sel)
                2'd0:    b = {2'b10, cp[5:0]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

// File: rtl/u16u8_front.sv
// Front end: takes UTF-16 code units, pairs surrogates, issues commands.
// Uses u16u8_pkg.
module u16u8_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [15:0]         code_unit,
    input  logic                string_last,
    input  logic                full,
    output logic                in_ready,
    output logic                push,
    output u16u8_pkg::cmd_t     cmd
);

    logic       held_valid_reg;
    logic       held_valid_next;
    logic [9:0] held_bits_reg;
    logic [9:0] held_bits_next;
    logic       is_hi;
    logic       is_lo;
    logic       take;

    assign in_ready = !full;
    assign take     = in_valid && in_ready;
    assign is_hi    = (code_unit[15:10] == u16u8_pkg::HI_TAG);
    assign is_lo    = (code_unit[15:10] == u16u8_pkg::LO_TAG);

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_bits_next  = held_bits_reg;
        cmd.flush       = 1'b0;
        cmd.flush_bits  = held_bits_reg;
        cmd.main        = 1'b0;
        cmd.cp          = {5'd0, code_unit};
        cmd.last        = string_last;
        if (held_valid_reg && is_lo) begin
            cmd.main        = 1'b1;
            cmd.cp          = 21'h10000 + {1'b0, held_bits_reg, code_unit[9:0]};
            held_valid_next = 1'b0;
            held_bits_next  = 10'd0;
        end else begin
            cmd.flush = held_valid_reg;
            if (is_hi && !string_last) begin
                held_valid_next = 1'b1;
                held_bits_next  = code_unit[9:0];
            end else begin
                cmd.main        = 1'b1;
                held_valid_next = 1'b0;
                held_bits_next  = 10'd0;
            end
        end
        push = take && (cmd.flush || cmd.main);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
            held_bits_reg  <= 10'd0;
        end else if (take) begin
            held_valid_reg <= held_valid_next;
            held_bits_reg  <= held_bits_next;
        end
    end

endmodule

// File: rtl/u16u8_fifo.sv
// Command queue between front and back, show-ahead.
// Uses u16u8_pkg.
module u16u8_fifo
#(
    parameter int DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u16u8_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output u16u8_pkg::cmd_t     head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u16u8_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/u16u8_back.sv
// Back end: walks each command one UTF-8 byte per cycle, unless output stalls,
// into an output register. Uses u16u8_pkg.
module u16u8_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  u16u8_pkg::cmd_t     head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                run_last,
    output logic                string_end
);

    logic        valid_reg;
    logic        valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        run_last_reg;
    logic        run_last_next;
    logic        str_end_reg;
    logic        str_end_next;
    logic        flush_done_reg;
    logic        flush_done_next;
    logic [1:0]  idx_reg;
    logic [1:0]  idx_next;
    logic        in_main;
    logic [20:0] cur_cp;
    logic [1:0]  nb;
    logic        phase_end;
    logic        advance;

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign string_end = str_end_reg;

    always_comb
    begin
        in_main   = !head.flush || flush_done_reg;
        cur_cp    = in_main ? head.cp : {5'd0, u16u8_pkg::HI_TAG, head.flush_bits};
        nb        = u16u8_pkg::utf8_nbytes_m1(cur_cp);
        phase_end = (idx_reg == nb);
        advance   = !valid_reg || out_ready;

        valid_next      = valid_reg;
        byte_next       = byte_reg;
        run_last_next   = run_last_reg;
        str_end_next    = str_end_reg;
        flush_done_next = flush_done_reg;
        idx_next        = idx_reg;
        pop             = 1'b0;

        if (advance) begin
            valid_next = head_valid;
            if (head_valid) begin
                byte_next     = u16u8_pkg::utf8_byte(cur_cp, nb, idx_reg);
                run_last_next = phase_end && (in_main || !head.main);
                str_end_next  = phase_end && (in_main || !head.main) && head.last;
                if (phase_end) begin
                    idx_next = 2'd0;
                    if (!in_main && head.main) begin
                        flush_done_next = 1'b1;
                    end else begin
                        flush_done_next = 1'b0;
                        pop             = 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg      <= 1'b0;
            flush_done_reg <= 1'b0;
            idx_reg        <= 2'd0;
        end else begin
            valid_reg      <= valid_next;
            flush_done_reg <= flush_done_next;
            idx_reg        <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        run_last_reg <= run_last_next;
        str_end_reg  <= str_end_next;
    end

endmodule

// File: rtl/utf16_to_utf8_transcoder.sv
// Top level of the UTF-16 to UTF-8 transcoder: front, command queue, back.
// Uses u16u8_pkg, u16u8_front, u16u8_fifo, u16u8_back.
//
//  channel  | direction | tdata             | tlast       | tuser
//  s_axis   | in        | [15:0] code_unit  | string_last | -
//  m_axis   | out       | [7:0]  out_byte   | run_last    | [0] string_end
//
// One output byte per cycle from the back end's byte sequencer, unless the output
// stalls; a unit yields 1 to 3 bytes (4 for a surrogate pair, up to 6 when a held
// surrogate is flushed). A high surrogate that is not last yields no byte and waits
// for its partner. Input is taken whenever the command queue has room; the back end
// drains it. Reset clears the held surrogate, the queue and the output valid flag.
module utf16_to_utf8_transcoder
#(
    parameter int QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] string_end
);

    u16u8_pkg::cmd_t push_cmd;
    u16u8_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            full;
    logic            not_empty;

    u16u8_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .code_unit   (s_axis_tdata),
        .string_last (s_axis_tlast),
        .full        (full),
        .in_ready    (s_axis_tready),
        .push        (push),
        .cmd         (push_cmd)
    );

    u16u8_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    u16u8_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .run_last   (m_axis_tlast),
        .string_end (m_axis_tuser[0])
    );

endmodule

// File: rtl/u16u8_checker.sv
// Port-level checks for the UTF-16 to UTF-8 transcoder, bound to the top level.
// Depends on utf16_to_utf8_transcoder.
module u16u8_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [0:0]  m_axis_tuser
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    a_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
        else $error("string end without run end");

    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:6] == 2'b11) |-> !m_axis_tlast)
        else $error("multi-byte lead byte closes a run");

    a_no_bad_lead: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] != 5'b11111) && (m_axis_tdata[7:1] != 7'b1100000))
        else $error("invalid or overlong UTF-8 lead byte");

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);

// File: test/utf16_to_utf8_transcoder_tb.sv
// Self-checking testbench for utf16_to_utf8_transcoder: directed and random UTF-16 strings.
// Models the UTF-8 encoding and surrogate handling in a scoreboard class; depends only on the RTL.
module utf16_to_utf8_transcoder_tb;

    localparam logic [15:0] HI_FIRST = 16'hD800;
    localparam logic [15:0] HI_LAST = 16'hDBFF;
    localparam logic [15:0] LO_FIRST = 16'hDC00;
    localparam logic [15:0] LO_LAST = 16'hDFFF;
    localparam int NUM_UNITS = 370;
    localparam int CALM_AFTER = 320;
    localparam int PAUSE_AT = 150;
    localparam int IDLE_LIMIT = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_DIRECTED = 24;

    // {string_last, code_unit}
    localparam logic [16:0] DIRECTED [NUM_DIRECTED] = '{
        17'h00000, 17'h0007F, 17'h00080, 17'h007FF, 17'h00800, 17'h1FFFF,
        17'h0D800, 17'h1DC00,
        17'h0DBFF, 17'h0DFFF,
        17'h1DBFF,
        17'h0D955, 17'h00041,
        17'h0DA00, 17'h0DB12, 17'h0DE34,
        17'h0D811, 17'h1D822,
        17'h0DC00, 17'h1DFFF,
        17'h0D800, 17'h10000,
        17'h0E000, 17'h1FFFE
    };

    typedef struct packed {
        logic [7:0] code_byte;
        logic       run_last;
        logic       string_end;
    } utf8_out_t;

    class utf8_byte_scoreboard;
        bit         held_valid;
        logic [9:0] held_bits;
        logic [7:0] staged[$];
        utf8_out_t  expected[$];
        int         errors;

        function new();
            held_valid = 1'b0;
            held_bits = '0;
            errors = 0;
        endfunction

        function void stage_byte(input logic [7:0] b);
            staged.insert(staged.size(), b);
        endfunction

        function void stage_code_point(input logic [20:0] cp);
            if (cp < 21'h80) begin
                stage_byte({1'b0, cp[6:0]});
            end else if (cp < 21'h800) begin
                stage_byte({3'b110, cp[10:6]});
                stage_byte({2'b10, cp[5:0]});
            end else if (cp < 21'h10000) begin
                stage_byte({4'b1110, cp[15:12]});
                stage_byte({2'b10, cp[11:6]});
                stage_byte({2'b10, cp[5:0]});
            end else begin
                stage_byte({5'b11110, cp[20:18]});
                stage_byte({2'b10, cp[17:12]});
                stage_byte({2'b10, cp[11:6]});
                stage_byte({2'b10, cp[5:0]});
            end
        endfunction

        function void note_unit(input logic [15:0] unit, input logic last);
            bit        is_hi;
            bit        is_lo;
            utf8_out_t item;
            is_hi = (unit >= HI_FIRST) && (unit <= HI_LAST);
            is_lo = (unit >= LO_FIRST) && (unit <= LO_LAST);
            staged.delete();
            if (held_valid && is_lo) begin
                stage_code_point(21'h10000 + {1'b0, held_bits, unit[9:0]});
                held_valid = 1'b0;
                held_bits = '0;
            end else begin
                // a held high surrogate not followed by its partner goes out alone
                if (held_valid) begin
                    stage_code_point(21'(HI_FIRST) + 21'(held_bits));
                    held_valid = 1'b0;
                    held_bits = '0;
                end
                if (is_hi && !last) begin
                    held_bits = unit[9:0];
                    held_valid = 1'b1;
                end else begin
                    stage_code_point({5'd0, unit});
                end
            end
            foreach (staged[k]) begin
                item.code_byte = staged[k];
                item.run_last = (k == staged.size() - 1);
                item.string_end = item.run_last && last;
                expected.insert(expected.size(), item);
            end
        endfunction

        function void check_byte(input utf8_out_t got);
            utf8_out_t want;
            if (expected.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("unexpected byte: data %h run_last %b string_end %b",
                             got.code_byte, got.run_last, got.string_end);
                end
            end else begin
                want = expected.pop_front();
                if (got.code_byte !== want.code_byte || got.run_last !== want.run_last ||
                    got.string_end !== want.string_end) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("mismatch: expected %h/%b/%b actual %h/%b/%b",
                                 want.code_byte, want.run_last, want.string_end,
                                 got.code_byte, got.run_last, got.string_end);
                    end
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // [15:0] code_unit
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] out_byte
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;         // [0] string_end

    logic idle_en = 1'b1;
    int   stall_left = 0;
    int   idle_cycles = 0;
    int   units_sent = 0;
    bit   paused_once = 1'b0;

    utf8_byte_scoreboard sb;

    utf16_to_utf8_transcoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    always #10 clk = ~clk;

    // output side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_byte({m_axis_tdata, m_axis_tlast, m_axis_tuser[0]});
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("utf16_to_utf8_transcoder regression: fail");
                $finish;
            end
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic last);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= unit;
        s_axis_tlast <= last;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_unit(unit, last);
        units_sent++;
    endtask

    task automatic send_random_strings();
        int   len;
        logic fin;
        while (units_sent < NUM_UNITS) begin
            if (units_sent >= CALM_AFTER) begin
                idle_en <= 1'b0;
            end
            // sender holds off until the output has fully drained
            if (!paused_once && units_sent >= PAUSE_AT) begin
                paused_once = 1'b1;
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.expected.size() > 0) @(posedge clk);
            end
            len = $urandom_range(1, 8);
            for (int p = 0; p < len; p++) begin
                fin = (p == len - 1);
                case ($urandom_range(0, 10))
                    0, 1, 2: send_unit(16'($urandom_range(0, 16'h007F)), fin);
                    3:       send_unit(16'($urandom_range(16'h0080, 16'h07FF)), fin);
                    4:       send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), fin);
                    5:       send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), fin);
                    6, 7:
                    begin
                        send_unit(16'($urandom_range(HI_FIRST, HI_LAST)), 1'b0);
                        send_unit(16'($urandom_range(LO_FIRST, LO_LAST)), fin);
                    end
                    8:       send_unit(16'($urandom_range(HI_FIRST, HI_LAST)), fin);
                    9:       send_unit(16'($urandom_range(LO_FIRST, LO_LAST)), fin);
                    default: send_unit(16'($urandom_range(0, 16'hFFFF)), fin);
                endcase
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (DIRECTED[i]) begin
            send_unit(DIRECTED[i][15:0], DIRECTED[i][16]);
        end
        send_random_strings();
        s_axis_tvalid <= 1'b0;
        while (sb.expected.size() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.expected.size() == 0) begin
            $display("utf16_to_utf8_transcoder regression: pass");
        end else begin
            $display("utf16_to_utf8_transcoder regression: fail");
        end
        $finish;
    end

endmodule
